// ===== hw/rtl/gdr_pkg.sv =====
// shared types and constants of the grid dda raycaster
package gdr_pkg;

  localparam int MAP_SIDE = 8;
  localparam int MAP_LOG  = 3;
  localparam int CELL_W   = 5;
  localparam int DIV_NW   = 31;
  localparam int DIV_DW   = 16;
  localparam int DIV_CW   = 5;
  localparam int IN_W     = 88;
  localparam int OUT_W    = 64;
  localparam int CFG_W    = 64;

  localparam logic [63:0] WALL_MAP_RESET = 64'hFF81A5BD95B181FF;
  localparam logic [11:0] NUM_RAYS_RESET = 12'd320;
  localparam logic        REG_WALL_MAP   = 1'b0;
  localparam logic        REG_NUM_RAYS   = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_PREP, OP_MX0, OP_MX1, OP_MY0, OP_MY1, OP_DSTART, OP_DSTORE,
    OP_AINIT, OP_ASTEP, OP_GSTEP, OP_MLO, OP_MHI, OP_DQ, OP_DIST0, OP_DIST1, OP_OUT
  } op_t;

  typedef enum logic [2:0] {DS_RX, DS_RY, DS_TX, DS_TY, DS_SX, DS_SY} dsel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_MX0, S_MX1, S_MY0, S_MY1, S_DGO, S_DWAIT, S_SEL,
    S_AINIT, S_ASTEP, S_GSTEP, S_MLO, S_MHI, S_DQ, S_DIST0, S_DIST1, S_OUT
  } state_t;

  typedef struct packed {
    op_t   op;
    dsel_t dsel;
    logic  ysel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic axis;
    logic stop;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/gdr_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module gdr_div import gdr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic [DIV_NW-1:0] quotient,
  output logic              done
);

  logic [DIV_DW-1:0] rem;
  logic [DIV_NW-1:0] quo;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial    = {rem, quo[DIV_NW-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CW'(DIV_NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? DIV_DW'(trial - {1'b0, divisor}) : trial[DIV_DW-1:0];
      quo <= {quo[DIV_NW-2:0], fits};
    end
  end

endmodule

// ===== hw/rtl/gdr_datapath.sv =====
// raycaster datapath: registers, ray setup, dda walk and result assembly
module gdr_datapath import gdr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_accept,
  input  logic [18:0]        pos_x,
  input  logic [18:0]        pos_y,
  input  logic signed [15:0] fwd_x,
  input  logic signed [15:0] fwd_y,
  input  logic [11:0]        column,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [19:0]        hit_x,
  output logic [19:0]        hit_y,
  output logic signed [20:0] distance,
  output logic               side,
  output logic               hit_found
);

  function automatic logic wall_at(input logic [63:0] map,
                                   input logic signed [CELL_W-1:0] x,
                                   input logic signed [CELL_W-1:0] y);
    logic outside;
    outside = (x < 0) || (y < 0) || (x >= CELL_W'(MAP_SIDE)) || (y >= CELL_W'(MAP_SIDE));
    return outside ? 1'b0 : map[{y[MAP_LOG-1:0], x[MAP_LOG-1:0]}];
  endfunction

  function automatic logic out_of_grid(input logic signed [CELL_W-1:0] x,
                                       input logic signed [CELL_W-1:0] y);
    return (x < 0) || (y < 0) || (x >= CELL_W'(MAP_SIDE)) || (y >= CELL_W'(MAP_SIDE));
  endfunction

  logic [63:0]               wall_map;
  logic [11:0]               num_rays;
  logic [18:0]               px, py;
  logic signed [15:0]        fx, fy;
  logic [11:0]               col;
  logic [13:0]               d;
  logic signed [14:0]        k;
  logic signed [31:0]        prod, num;
  logic signed [16:0]        rx, ry;
  logic [34:0]               tx, ty, t;
  logic [30:0]               sx, sy;
  logic signed [CELL_W-1:0]  cx, cy;
  logic                      gside, hit;
  logic [50:0]               acc;
  logic signed [23:0]        dxq, dyq;
  logic signed [40:0]        sum;

  // setup
  logic [11:0]        n, r;
  logic signed [13:0] two_r_n;
  logic signed [15:0] k3;
  logic signed [30:0] mul_d, mul_k;
  assign n       = (num_rays == '0) ? 12'd1 : num_rays;
  assign r       = (col > n - 12'd1) ? n - 12'd1 : col;
  assign two_r_n = $signed({1'b0, r, 1'b0}) - $signed({2'b00, n});
  assign k3      = ($signed({{2{two_r_n[13]}}, two_r_n}) <<< 1) + $signed({{2{two_r_n[13]}}, two_r_n});
  assign mul_d   = $signed({1'b0, d}) * ((cmd.op == OP_MX0) ? fx : fy);
  assign mul_k   = k * ((cmd.op == OP_MX1) ? fy : fx);

  // divider operands
  logic [31:0]       num_mag;
  logic [15:0]       ax, ay;
  logic              xpos, ypos, axis, axis_x;
  logic [16:0]       edge_x, edge_y;
  logic [DIV_NW-1:0] dvd, quo;
  logic [DIV_DW-1:0] dvs;
  logic              div_start, div_done;
  logic signed [16:0] qs;

  assign num_mag = num[31] ? 32'(-num) : 32'(num);
  assign ax      = rx[16] ? 16'(-rx) : 16'(rx);
  assign ay      = ry[16] ? 16'(-ry) : 16'(ry);
  assign xpos    = !rx[16] && (rx != '0);
  assign ypos    = !ry[16] && (ry != '0);
  assign axis    = (rx == '0) || (ry == '0);
  assign axis_x  = (ry == '0);
  assign edge_x  = xpos ? 17'h10000 - {1'b0, px[15:0]} : {1'b0, px[15:0]};
  assign edge_y  = ypos ? 17'h10000 - {1'b0, py[15:0]} : {1'b0, py[15:0]};
  assign div_start = (cmd.op == OP_DSTART);
  assign qs      = num[31] ? -$signed(quo[16:0]) : $signed(quo[16:0]);

  always_comb begin
    unique case (cmd.dsel)
      DS_RX, DS_RY: begin
        dvd = DIV_NW'(num_mag + {19'd0, d[13:1]});
        dvs = {2'b00, d};
      end
      DS_TX: begin
        dvd = {edge_x, 14'd0};
        dvs = ax;
      end
      DS_TY: begin
        dvd = {edge_y, 14'd0};
        dvs = ay;
      end
      DS_SX: begin
        dvd = DIV_NW'(1) << 30;
        dvs = ax;
      end
      DS_SY: begin
        dvd = DIV_NW'(1) << 30;
        dvs = ay;
      end
      default: begin
        dvd = '0;
        dvs = '1;
      end
    endcase
  end

  gdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quo),
    .done     (div_done)
  );

  // cell walk
  logic signed [CELL_W-1:0] stx, sty, ncx, ncy;
  logic                     take_x, a_wall, g_wall, a_stop, g_stop;
  assign stx    = xpos ? CELL_W'(1) : CELL_W'(-1);
  assign sty    = ypos ? CELL_W'(1) : CELL_W'(-1);
  assign take_x = tx < ty;
  assign ncx    = take_x ? cx + stx : cx;
  assign ncy    = take_x ? cy : cy + sty;
  assign a_wall = wall_at(wall_map, cx, cy);
  assign g_wall = wall_at(wall_map, ncx, ncy);
  assign a_stop = out_of_grid(cx, cy) || a_wall;
  assign g_stop = out_of_grid(ncx, ncy) || g_wall;

  // displacement and distance
  logic [15:0]        amag;
  logic [50:0]        acc_r;
  logic [22:0]        mq;
  logic signed [23:0] dq;
  assign amag  = cmd.ysel ? ay : ax;
  assign acc_r = acc + 51'd8192;
  assign mq    = acc_r[36:14];
  assign dq    = (cmd.ysel ? ry[16] : rx[16]) ? -$signed({1'b0, mq}) : $signed({1'b0, mq});

  // result
  logic [40:0]        sabs, sabs_r;
  logic [26:0]        mr;
  logic signed [20:0] gdist, adist, fdist;
  logic [3:0]         ex, ey;
  logic [19:0]        edgx, edgy, cpx, cpy, fhx, fhy;
  logic signed [24:0] spx, spy;
  logic               fside;

  assign sabs   = sum[40] ? 41'(-sum) : 41'(sum);
  assign sabs_r = sabs + 41'd8192;
  assign mr     = sabs_r[40:14];
  assign gdist  = sum[40] ? 21'sd0 : ((mr > 27'd1048575) ? 21'sd1048575 : $signed({1'b0, mr[19:0]}));
  assign ex     = xpos ? cx[3:0] : 4'(cx + CELL_W'(1));
  assign ey     = ypos ? cy[3:0] : 4'(cy + CELL_W'(1));
  assign edgx   = {ex, 16'd0};
  assign edgy   = {ey, 16'd0};
  assign spx    = $signed({6'd0, px}) + dxq;
  assign spy    = $signed({6'd0, py}) + dyq;
  assign cpx    = spx[24] ? 20'd0 : ((spx > 25'sd524288) ? 20'd524288 : spx[19:0]);
  assign cpy    = spy[24] ? 20'd0 : ((spy > 25'sd524288) ? 20'd524288 : spy[19:0]);

  always_comb begin
    if (axis) begin
      fside = !axis_x;
      if (axis_x) begin
        fhx   = edgx;
        fhy   = {1'b0, py};
        adist = xpos ? $signed({1'b0, edgx}) - $signed({2'b00, px})
                     : $signed({2'b00, px}) - $signed({1'b0, edgx});
      end else begin
        fhx   = {1'b0, px};
        fhy   = edgy;
        adist = ypos ? $signed({1'b0, edgy}) - $signed({2'b00, py})
                     : $signed({2'b00, py}) - $signed({1'b0, edgy});
      end
      fdist = hit ? adist : -21'sd65536;
    end else begin
      fside = gside;
      adist = '0;
      fhx   = gside ? cpx : edgx;
      fhy   = gside ? edgy : cpy;
      fdist = gdist;
    end
  end

  assign stat.div_done = div_done;
  assign stat.axis     = axis;
  assign stat.stop     = (cmd.op == OP_GSTEP) ? g_stop : a_stop;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_map <= WALL_MAP_RESET;
      num_rays <= NUM_RAYS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_WALL_MAP) begin
        wall_map <= cfg_data;
      end else begin
        num_rays <= cfg_data[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT && stat.out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      px  <= pos_x;
      py  <= pos_y;
      fx  <= fwd_x;
      fy  <= fwd_y;
      col <= column;
      hit <= 1'b0;
    end
    unique case (cmd.op)
      OP_PREP: begin
        d  <= {n, 2'b00};
        k  <= k3[14:0];
        cx <= $signed({2'b00, px[18:16]});
        cy <= $signed({2'b00, py[18:16]});
      end
      OP_MX0, OP_MY0: prod <= 32'(mul_d);
      OP_MX1: num <= prod - 32'(mul_k);
      OP_MY1: num <= prod + 32'(mul_k);
      OP_DSTORE: begin
        unique case (cmd.dsel)
          DS_RX:   rx <= qs;
          DS_RY:   ry <= qs;
          DS_TX:   tx <= {4'd0, quo};
          DS_TY:   ty <= {4'd0, quo};
          DS_SX:   sx <= quo;
          DS_SY:   sy <= quo;
          default: ;
        endcase
      end
      OP_AINIT: begin
        cx <= $signed({2'b00, px[18:16]}) + (axis_x ? stx : CELL_W'(0));
        cy <= $signed({2'b00, py[18:16]}) + (axis_x ? CELL_W'(0) : sty);
      end
      OP_ASTEP: begin
        if (a_stop) begin
          hit <= a_wall;
        end else if (axis_x) begin
          cx <= cx + stx;
        end else begin
          cy <= cy + sty;
        end
      end
      OP_GSTEP: begin
        cx    <= ncx;
        cy    <= ncy;
        gside <= !take_x;
        hit   <= g_wall;
        if (take_x) begin
          t  <= tx;
          tx <= tx + {4'd0, sx};
        end else begin
          t  <= ty;
          ty <= ty + {4'd0, sy};
        end
      end
      OP_MLO: acc <= 51'({16'd0, t[17:0]} * {18'd0, amag});
      OP_MHI: acc <= acc + {({16'd0, t[34:18]} * {17'd0, amag}), 18'd0};
      OP_DQ: begin
        if (cmd.ysel) begin
          dyq <= dq;
        end else begin
          dxq <= dq;
        end
      end
      OP_DIST0: sum <= dxq * fx;
      OP_DIST1: sum <= sum + dyq * fy;
      OP_OUT: begin
        if (stat.out_free) begin
          hit_x     <= fhx;
          hit_y     <= fhy;
          distance  <= fdist;
          side      <= fside;
          hit_found <= hit;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/gdr_ctrl.sv =====
// raycaster controller: sequences setup, divisions, walk and result
module gdr_ctrl import gdr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  dsel_t  dsel, dsel_next;
  logic   ysel, ysel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dsel  <= DS_RX;
      ysel  <= 1'b0;
    end else begin
      state <= state_next;
      dsel  <= dsel_next;
      ysel  <= ysel_next;
    end
  end

  always_comb begin
    state_next = state;
    dsel_next  = dsel;
    ysel_next  = ysel;
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.dsel   = dsel;
    cmd.ysel   = ysel;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op     = OP_PREP;
        state_next = S_MX0;
      end
      S_MX0: begin
        cmd.op     = OP_MX0;
        state_next = S_MX1;
      end
      S_MX1: begin
        cmd.op     = OP_MX1;
        dsel_next  = DS_RX;
        state_next = S_DGO;
      end
      S_MY0: begin
        cmd.op     = OP_MY0;
        state_next = S_MY1;
      end
      S_MY1: begin
        cmd.op     = OP_MY1;
        dsel_next  = DS_RY;
        state_next = S_DGO;
      end
      S_DGO: begin
        cmd.op     = OP_DSTART;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.op = OP_DSTORE;
          unique case (dsel)
            DS_RX: state_next = S_MY0;
            DS_RY: state_next = S_SEL;
            DS_TX: begin
              dsel_next  = DS_TY;
              state_next = S_DGO;
            end
            DS_TY: begin
              dsel_next  = DS_SX;
              state_next = S_DGO;
            end
            DS_SX: begin
              dsel_next  = DS_SY;
              state_next = S_DGO;
            end
            DS_SY:   state_next = S_GSTEP;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SEL: begin
        if (stat.axis) begin
          state_next = S_AINIT;
        end else begin
          dsel_next  = DS_TX;
          state_next = S_DGO;
        end
      end
      S_AINIT: begin
        cmd.op     = OP_AINIT;
        state_next = S_ASTEP;
      end
      S_ASTEP: begin
        cmd.op = OP_ASTEP;
        if (stat.stop) begin
          state_next = S_OUT;
        end
      end
      S_GSTEP: begin
        cmd.op = OP_GSTEP;
        if (stat.stop) begin
          ysel_next  = 1'b0;
          state_next = S_MLO;
        end
      end
      S_MLO: begin
        cmd.op     = OP_MLO;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.op     = OP_MHI;
        state_next = S_DQ;
      end
      S_DQ: begin
        cmd.op = OP_DQ;
        if (ysel) begin
          state_next = S_DIST0;
        end else begin
          ysel_next  = 1'b1;
          state_next = S_MLO;
        end
      end
      S_DIST0: begin
        cmd.op     = OP_DIST0;
        state_next = S_DIST1;
      end
      S_DIST1: begin
        cmd.op     = OP_DIST1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.op = OP_OUT;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/grid_dda_raycaster.sv =====
// Grid DDA raycaster top level.
// Each request on the s_axis channel carries the player position, the
// forward vector and a screen column; exactly one result per request leaves
// on the m_axis channel: hit point, projected distance, crossed face and a
// hit flag. The 8x8 wall map and the ray count are set through the cfg
// write port (index 0 wall map, index 1 ray count); the user must write
// them only while the block is idle; the block itself does not enforce it.
// One request is worked on at a time, and every division goes through the
// single shared bit-serial divider: a ray lying on an axis takes two
// divides and then one step per scanned cell; any other ray takes six
// divides, one walk step per crossed cell, then multiply and rounding.
// The result sits in an output register; s_axis_tready returns in the cycle
// after the result is registered, so the next request is taken while the
// previous result still waits. A stalled receiver holds the finished result
// and the block waits with the next one. Reset clears the controller and
// the output valid, and restores the default wall map and a ray count of 320.
module grid_dda_raycaster import gdr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // pos_x[18:0] pos_y[37:19] fwd_x[53:38] fwd_y[69:54] column[81:70]
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // hit_x[19:0] hit_y[39:20] distance[60:40] side[61] hit_found[62]
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t               cmd;
  stat_t              stat;
  logic [19:0]        hit_x, hit_y;
  logic signed [20:0] distance;
  logic               side, hit_found;

  gdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gdr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (s_axis_tvalid && s_axis_tready),
    .pos_x     (s_axis_tdata[18:0]),
    .pos_y     (s_axis_tdata[37:19]),
    .fwd_x     ($signed(s_axis_tdata[53:38])),
    .fwd_y     ($signed(s_axis_tdata[69:54])),
    .column    (s_axis_tdata[81:70]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .hit_x     (hit_x),
    .hit_y     (hit_y),
    .distance  (distance),
    .side      (side),
    .hit_found (hit_found)
  );

  assign m_axis_tdata = {1'b0, hit_found, side, distance, hit_y, hit_x};

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the grid dda raycaster: predicted rays vs block results
class ray_board;
  logic [63:0] wmap;
  int unsigned nrays;
  logic [63:0] pend[$];
  int errors;
  int seen;

  function new();
    wmap = gdr_pkg::WALL_MAP_RESET;
    nrays = gdr_pkg::NUM_RAYS_RESET;
    errors = 0;
    seen = 0;
  endfunction

  function bit wall(longint x, longint y);
    if (x < 0 || y < 0 || x >= 8 || y >= 8) return 0;
    return wmap[y * 8 + x];
  endfunction

  function longint rdiv(longint num, longint den);
    longint m;
    m = ((num < 0 ? -num : num) + den / 2) / den;
    return num < 0 ? -m : m;
  endfunction

  function longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function logic [63:0] cast_ray(logic [87:0] req);
    longint px, py, fx, fy, n, r, d, k, rx, ry, cx, cy, c;
    longint ax, ay, tx, ty, sx, sy, t, dxq, dyq, wdist, hx, hy;
    int side, hit, s;
    logic [63:0] o;
    px = req[18:0];
    py = req[37:19];
    fx = longint'($signed(req[53:38]));
    fy = longint'($signed(req[69:54]));
    r = req[81:70];
    n = nrays ? nrays : 1;
    if (r > n - 1) r = n - 1;
    d = 4 * n;
    k = 3 * (2 * r - n);
    rx = rdiv(d * fx - k * fy, d);
    ry = rdiv(d * fy + k * fx, d);
    t = 0; side = 0; hit = 0;
    cx = px >>> 16;
    cy = py >>> 16;
    if (rx == 0 || ry == 0) begin
      wdist = -65536;
      if (ry == 0) begin
        side = 0; hy = py;
        if (rx > 0) begin
          hx = 8 << 16;
          for (c = cx + 1; c < 8; c++)
            if (wall(c, cy)) begin
              hx = c << 16; wdist = hx - px; hit = 1; break;
            end
        end else begin
          hx = 0;
          for (c = cx - 1; c >= 0; c--)
            if (wall(c, cy)) begin
              hx = (c + 1) << 16; wdist = px - hx; hit = 1; break;
            end
        end
      end else begin
        side = 1; hx = px;
        if (ry > 0) begin
          hy = 8 << 16;
          for (c = cy + 1; c < 8; c++)
            if (wall(cx, c)) begin
              hy = c << 16; wdist = hy - py; hit = 1; break;
            end
        end else begin
          hy = 0;
          for (c = cy - 1; c >= 0; c--)
            if (wall(cx, c)) begin
              hy = (c + 1) << 16; wdist = py - hy; hit = 1; break;
            end
        end
      end
    end else begin
      ax = rx < 0 ? -rx : rx;
      ay = ry < 0 ? -ry : ry;
      tx = ((rx > 0) ? 65536 - (px & 16'hFFFF) : (px & 16'hFFFF)) * 16384 / ax;
      ty = ((ry > 0) ? 65536 - (py & 16'hFFFF) : (py & 16'hFFFF)) * 16384 / ay;
      sx = (64'd1 << 30) / ax;
      sy = (64'd1 << 30) / ay;
      for (s = 0; s < 18; s++) begin
        if (tx < ty) begin
          t = tx; cx += (rx > 0) ? 1 : -1; tx += sx; side = 0;
        end else begin
          t = ty; cy += (ry > 0) ? 1 : -1; ty += sy; side = 1;
        end
        if (cx < 0 || cy < 0 || cx >= 8 || cy >= 8) break;
        if (wall(cx, cy)) begin
          hit = 1; break;
        end
      end
      dxq = rdiv(t * rx, 16384);
      dyq = rdiv(t * ry, 16384);
      wdist = clip(rdiv(dxq * fx + dyq * fy, 16384), 0, 1048575);
      if (side == 0) begin
        hx = ((rx > 0) ? cx : cx + 1) << 16;
        hy = clip(py + dyq, 0, 524288);
      end else begin
        hy = ((ry > 0) ? cy : cy + 1) << 16;
        hx = clip(px + dxq, 0, 524288);
      end
    end
    o = '0;
    o[19:0] = hx[19:0];
    o[39:20] = hy[19:0];
    o[60:40] = wdist[20:0];
    o[61] = side[0];
    o[62] = hit[0];
    return o;
  endfunction

  function void note_request(logic [87:0] req);
    pend.push_back(cast_ray(req));
  endfunction

  function void check_result(logic [63:0] got);
    logic [63:0] e;
    seen++;
    if (pend.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    e = pend.pop_front();
    if (got[19:0] !== e[19:0] || got[39:20] !== e[39:20] || got[60:40] !== e[60:40] ||
        got[61] !== e[61] || got[62] !== e[62]) begin
      $display("%0t: mismatch exp x=%h y=%h d=%h s=%b h=%b act x=%h y=%h d=%h s=%b h=%b",
               $time, e[19:0], e[39:20], e[60:40], e[61], e[62],
               got[19:0], got[39:20], got[60:40], got[61], got[62]);
      errors++;
    end
  endfunction
endclass

module tb;
  import gdr_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we = 0;
  logic cfg_index = REG_WALL_MAP;
  logic [CFG_W-1:0] cfg_data = '0;

  int send_idle = 0;
  int recv_stall = 0;
  int requests = 0;
  ray_board board;

  grid_dda_raycaster dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);

  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= recv_stall);

  task automatic write_reg(logic idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_WALL_MAP) board.wmap = val;
    else board.nrays = val[11:0];
  endtask

  task automatic send_ray(logic [18:0] px, logic [18:0] py, logic [15:0] fx,
                          logic [15:0] fy, logic [11:0] col);
    logic [87:0] req;
    req = {6'd0, col, fy, fx, py, px};
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= req;
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(req);
    requests++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pend.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic random_ray();
    logic [15:0] fx, fy;
    logic [18:0] px, py;
    int mode;
    mode = $urandom_range(9);
    if (mode == 0) begin
      fx = 16'($urandom); fy = 16'($urandom); px = 19'($urandom); py = 19'($urandom);
    end else begin
      int a;
      real ang;
      a = $urandom_range(4095);
      ang = a * 6.283185307 / 4096.0;
      fx = 16'($rtoi($floor(16384.0 * $cos(ang) + 0.5)));
      fy = 16'($rtoi($floor(16384.0 * $sin(ang) + 0.5)));
      if (mode == 1) begin
        case ($urandom_range(3))
          0: begin fx = 16384; fy = 0; end
          1: begin fx = -16384; fy = 0; end
          2: begin fx = 0; fy = 16384; end
          default: begin fx = 0; fy = -16384; end
        endcase
      end
      px = 19'($urandom_range(7 << 16, 0));
      py = 19'($urandom_range(7 << 16, 0));
      if (mode == 2) px = 19'($urandom_range(7) << 16);
    end
    send_ray(px, py, fx, fy, (mode == 3) ? 12'($urandom) :
             12'($urandom_range(board.nrays ? board.nrays - 1 : 0)));
  endtask

  initial begin
    #40_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    int ph;
    board = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, axis and diagonal cases on the reset map
    send_ray(19'h18000, 19'h18000, 16384, 0, 0);
    send_ray(19'h18000, 19'h18000, 16384, 0, 160);
    send_ray(19'h18000, 19'h18000, -16384, 0, 160);
    send_ray(19'h18000, 19'h18000, 0, 16384, 160);
    send_ray(19'h18000, 19'h18000, 0, -16384, 160);
    send_ray(19'h18000, 19'h18000, 0, 0, 160);
    send_ray(19'h7FFFF, 19'h7FFFF, 16'h8000, 16'h7FFF, 12'hFFF);
    send_ray(0, 0, 16'h7FFF, 16'h8000, 319);
    send_ray(19'h4A000, 19'h23456, 11585, 11585, 319);
    send_ray(19'h4A000, 19'h23456, -11585, 11585, 0);
    send_ray(19'h4A000, 19'h23456, 11585, -11585, 4000);
    drain();
    write_reg(REG_WALL_MAP, 64'h0);
    write_reg(REG_NUM_RAYS, 12'd0);
    send_ray(19'h30000, 19'h30000, 16384, 0, 5);
    send_ray(19'h30000, 19'h30000, 0, -16384, 0);
    send_ray(19'h30000, 19'h30000, 9000, 13000, 0);
    send_ray(19'h30000, 19'h30000, -9000, -13000, 0);
    drain();
    write_reg(REG_NUM_RAYS, 12'd4095);
    write_reg(REG_WALL_MAP, 64'hFFFF_FFFF_FFFF_FFFF);
    send_ray(19'h30000, 19'h30000, 9000, 13000, 4095);
    send_ray(19'h30000, 19'h30000, 9000, -13000, 0);
    drain();
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 52; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 52; end
        default: begin send_idle = 12; recv_stall = 12; end
      endcase
      write_reg(REG_WALL_MAP, (ph == 0) ? WALL_MAP_RESET : {$urandom, $urandom});
      write_reg(REG_NUM_RAYS, (ph == 7) ? 12'd1 : 12'($urandom_range(4095, 1)));
      repeat (85) random_ray();
      drain();
    end
    $display("covered %0d rays, %0d results, axis and diagonal rays on several maps",
             requests, board.seen);
    if (board.errors == 0 && board.pend.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end
endmodule
